/* rtl/core/pit_pkg.sv */
// ----------------------------------------------------------------------------
// pit_pkg: shared types and constants of the PWM interval timer
// Item layouts, command and register codes, and the fixed-point constants
// used to turn a duty percentage into a compare value.
// ----------------------------------------------------------------------------
`default_nettype none

package pit_pkg;

  // Widths that the item and register layouts fix.
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned LEVEL_W   = 4;
  localparam int unsigned REG_IDX_W = 3;

  // Duty scaling: floor(x / 100) == (x * RECIP_MULT) >> RECIP_SHIFT for every
  // x below 2^23, which covers reload * duty (at most 65535 * 100).
  localparam int unsigned    DUTY_FULL   = 100;
  localparam int unsigned    RECIP_SHIFT = 30;
  localparam int unsigned    RECIP_W     = 24;
  localparam logic [23:0]    RECIP_MULT  = 24'd10737419;
  localparam int unsigned    SCALED_W    = DATA_W + RECIP_W;
  localparam int unsigned    DUTY_W      = 7;

  // Commands carried by an input item.
  typedef enum logic [2:0] {
    KIND_TICK       = 3'd0,
    KIND_START      = 3'd1,
    KIND_STOP       = 3'd2,
    KIND_SET_DUTY   = 3'd3,
    KIND_QUERY      = 3'd4,
    KIND_CLEAR_FLAG = 3'd5
  } kind_e;

  // Counting modes; the unused code counts up.
  typedef enum logic [1:0] {
    MODE_UP     = 2'd0,
    MODE_DOWN   = 2'd1,
    MODE_CENTER = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PRESCALE       = 3'd0,
    REG_RELOAD         = 3'd1,
    REG_COUNT_MODE     = 3'd2,
    REG_ONE_SHOT       = 3'd3,
    REG_IRQ_ENABLE     = 3'd4,
    REG_CHANNEL_ENABLE = 3'd5,
    REG_PWM_MODE_BITS  = 3'd6,
    REG_ACTIVE_LOW     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] channel;
    logic [7:0] duty_percent;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pwm_level;
    logic               update_event;
    logic               update_flag;
    logic [DATA_W-1:0]  count_value;
    logic [DATA_W-1:0]  remaining;
    logic               running;
  } out_item_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    wdata;
  } cfg_write_t;

  // Register file contents as seen by the timer core.
  typedef struct packed {
    logic [DATA_W-1:0]   prescale;
    logic [DATA_W-1:0]   reload;
    logic [1:0]          count_mode;
    logic                one_shot;
    logic                irq_enable;
    logic [LEVEL_W-1:0]  channel_enable;
    logic [LEVEL_W-1:0]  pwm_mode_bits;
    logic [LEVEL_W-1:0]  active_low;
    logic [SCALED_W-1:0] reload_scaled;
  } cfg_t;

endpackage : pit_pkg

`default_nettype wire

/* rtl/core/pit_stream_if.sv */
// ----------------------------------------------------------------------------
// pit_stream_if: valid/ready channel
// Carries one item per handshake from a source to a sink.
// ----------------------------------------------------------------------------
`default_nettype none

interface pit_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface : pit_stream_if

`default_nettype wire

/* rtl/core/pit_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pit_cfg_regs: configuration register file
// Holds the timer settings and keeps the reload value pre-multiplied by the
// reciprocal of one hundred for the duty conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_cfg_regs
  import pit_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_valid_i,
  input  wire cfg_write_t wr_i,
  output cfg_t            cfg_o
);

  // Reset values: every register clears except the polarity bits, which
  // start inverted.
  localparam cfg_t CFG_RESET = '{
    prescale:       '0,
    reload:         '0,
    count_mode:     '0,
    one_shot:       1'b0,
    irq_enable:     1'b0,
    channel_enable: '0,
    pwm_mode_bits:  '0,
    active_low:     '1,
    reload_scaled:  '0
  };

  cfg_t              cfg_q;
  logic [DATA_W-1:0] top_w;

  // The reload as the counter sees it, taken modulo 2^COUNT_WIDTH.
  assign top_w = DATA_W'(COUNT_WIDTH'(wr_i.wdata));

  // Register writes; the scaled reload follows every reload write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (wr_valid_i) begin
      case (wr_i.index)
        REG_PRESCALE: begin
          cfg_q.prescale <= wr_i.wdata;
        end
        REG_RELOAD: begin
          cfg_q.reload        <= wr_i.wdata;
          cfg_q.reload_scaled <= SCALED_W'(top_w) * SCALED_W'(RECIP_MULT);
        end
        REG_COUNT_MODE: begin
          cfg_q.count_mode <= wr_i.wdata[1:0];
        end
        REG_ONE_SHOT: begin
          cfg_q.one_shot <= wr_i.wdata[0];
        end
        REG_IRQ_ENABLE: begin
          cfg_q.irq_enable <= wr_i.wdata[0];
        end
        REG_CHANNEL_ENABLE: begin
          cfg_q.channel_enable <= wr_i.wdata[LEVEL_W-1:0];
        end
        REG_PWM_MODE_BITS: begin
          cfg_q.pwm_mode_bits <= wr_i.wdata[LEVEL_W-1:0];
        end
        REG_ACTIVE_LOW: begin
          cfg_q.active_low <= wr_i.wdata[LEVEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule : pit_cfg_regs

`default_nettype wire

/* rtl/core/pit_core.sv */
// ----------------------------------------------------------------------------
// pit_core: timer state and per-item update
// Registers the incoming item, then applies it to the prescaler, counter,
// flag and compare values in one pass and forms the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_core
  import pit_pkg::*;
#(
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     in_valid_i,
  input  wire in_item_t in_data_i,
  output logic          in_ready_o,
  input  wire logic     buf_full_i,
  output logic          res_valid_o,
  output out_item_t     res_o
);

  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned CMP_W = (CW > DATA_W) ? CW : DATA_W;

  in_item_t          item_q;
  logic              item_valid_q;
  logic              advance;

  logic [DATA_W-1:0] presc_q, presc_d;
  logic [CW-1:0]     counter_q, counter_d;
  logic              going_down_q, going_down_d;
  logic              enabled_q, enabled_d;
  logic              flag_q, flag_d;
  logic [DATA_W-1:0] pulse_q [CHANNELS];
  logic [DATA_W-1:0] pulse_d [CHANNELS];

  logic [CW-1:0]          top;
  logic [CW:0]            cnt_inc;
  logic [CW-1:0]          step_cnt;
  logic                   step_down;
  logic                   step_upd;
  logic                   upd;
  logic [DUTY_W-1:0]      duty_sat;
  logic [SCALED_W+DUTY_W-1:0] duty_prod;
  logic [DATA_W-1:0]      pulse_new;
  logic [LEVEL_W-1:0]     levels;
  logic                   active;

  // Input register: refills whenever the held item moves on.
  assign advance     = item_valid_q & ~buf_full_i;
  assign in_ready_o  = ~item_valid_q | ~buf_full_i;
  assign res_valid_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  // One counter step in the configured mode.
  assign top     = CW'(cfg_i.reload);
  assign cnt_inc = {1'b0, counter_q} + {{CW{1'b0}}, 1'b1};

  always_comb begin
    step_cnt  = counter_q;
    step_down = going_down_q;
    step_upd  = 1'b0;
    if (cfg_i.count_mode == MODE_DOWN) begin
      if (counter_q == '0) begin
        step_cnt = top;
        step_upd = 1'b1;
      end else begin
        step_cnt = counter_q - CW'(1);
      end
    end else if (cfg_i.count_mode == MODE_CENTER) begin
      if (!going_down_q) begin
        if (cnt_inc >= {1'b0, top}) begin
          step_cnt  = top;
          step_down = 1'b1;
          step_upd  = 1'b1;
        end else begin
          step_cnt = cnt_inc[CW-1:0];
        end
      end else if (counter_q <= CW'(1)) begin
        step_cnt  = '0;
        step_down = 1'b0;
        step_upd  = 1'b1;
      end else begin
        step_cnt = counter_q - CW'(1);
      end
    end else begin
      if (counter_q >= top) begin
        step_cnt = '0;
        step_upd = 1'b1;
      end else begin
        step_cnt = cnt_inc[CW-1:0];
      end
    end
  end

  // Duty to compare value: reload * min(duty, 100) / 100 via the reciprocal.
  assign duty_sat  = (item_q.duty_percent > 8'(DUTY_FULL)) ? DUTY_W'(DUTY_FULL)
                                                           : item_q.duty_percent[DUTY_W-1:0];
  assign duty_prod = (SCALED_W+DUTY_W)'(cfg_i.reload_scaled) * (SCALED_W+DUTY_W)'(duty_sat);
  assign pulse_new = duty_prod[RECIP_SHIFT +: DATA_W];

  // Next state for the held item.
  always_comb begin
    presc_d      = presc_q;
    counter_d    = counter_q;
    going_down_d = going_down_q;
    enabled_d    = enabled_q;
    flag_d       = flag_q;
    upd          = 1'b0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      pulse_d[ch] = pulse_q[ch];
    end
    case (item_q.kind)
      KIND_TICK: begin
        if (enabled_q) begin
          if (presc_q >= cfg_i.prescale) begin
            presc_d      = '0;
            counter_d    = step_cnt;
            going_down_d = step_down;
            upd          = step_upd;
          end else begin
            presc_d = presc_q + DATA_W'(1);
          end
          if (upd) begin
            flag_d = 1'b1;
            if (cfg_i.one_shot) begin
              enabled_d = 1'b0;
            end
          end
        end
      end
      KIND_START: begin
        enabled_d = 1'b1;
        if (!cfg_i.one_shot) begin
          flag_d = 1'b0;
        end
      end
      KIND_STOP: begin
        enabled_d = 1'b0;
      end
      KIND_SET_DUTY: begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          if (item_q.channel == 2'(ch)) begin
            pulse_d[ch] = pulse_new;
          end
        end
      end
      KIND_CLEAR_FLAG: begin
        flag_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Channel outputs from the updated counter and compare values.
  always_comb begin
    levels = '0;
    active = 1'b0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      active = CMP_W'(counter_d) < CMP_W'(pulse_d[ch]);
      active = active ^ cfg_i.pwm_mode_bits[ch] ^ cfg_i.active_low[ch];
      levels[ch] = active & cfg_i.channel_enable[ch];
    end
  end

  // Result item.
  always_comb begin
    res_o.pwm_level    = levels;
    res_o.update_event = upd & cfg_i.irq_enable;
    res_o.update_flag  = flag_d;
    res_o.count_value  = DATA_W'(counter_d);
    res_o.running      = enabled_d;
    if (cfg_i.count_mode == MODE_DOWN || cfg_i.count_mode == MODE_CENTER) begin
      res_o.remaining = DATA_W'(counter_d);
    end else begin
      res_o.remaining = cfg_i.reload - DATA_W'(counter_d);
    end
  end

  // State registers move only when the item leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q      <= '0;
      counter_q    <= '0;
      going_down_q <= 1'b0;
      enabled_q    <= 1'b0;
      flag_q       <= 1'b0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        pulse_q[ch] <= '0;
      end
    end else if (advance) begin
      presc_q      <= presc_d;
      counter_q    <= counter_d;
      going_down_q <= going_down_d;
      enabled_q    <= enabled_d;
      flag_q       <= flag_d;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        pulse_q[ch] <= pulse_d[ch];
      end
    end
  end

endmodule : pit_core

`default_nettype wire

/* rtl/core/pit_out_buf.sv */
// ----------------------------------------------------------------------------
// pit_out_buf: result register with skid stage
// Holds the result on offer and one more behind it, so the core can hand
// over one more result while the consumer stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_out_buf
  import pit_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire out_item_t push_data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  logic      out_valid_q;
  logic      skid_valid_q;
  out_item_t out_q;
  out_item_t skid_q;
  logic      pop;

  assign pop = out_valid_q & out_ready_i;

  // Control: the skid stage fills only when the result register is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q  <= skid_valid_q | push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Data: the older item always leaves first.
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule : pit_out_buf

`default_nettype wire

/* rtl/core/pwm_interval_timer.sv */
// ----------------------------------------------------------------------------
// pwm_interval_timer: general purpose timer with four PWM channels
// The input register holds each accepted item; its result is formed from it and
// enters the result register, or the skid stage while the output stalls.
// Throughput: one item per cycle while the skid stage is free; each item's
// state update is a single pass. Reset clears the timer state and returns the
// registers to their reset values; items are accepted as soon as reset ends.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_interval_timer
  import pit_pkg::*;
#(
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pit_stream_if.sink   in_i,
  pit_stream_if.sink   cfg_i,
  pit_stream_if.source out_o
);

  cfg_t       cfg;
  cfg_write_t cfg_wr;
  in_item_t   in_data;
  out_item_t  res;
  out_item_t  out_data;
  logic       in_ready;
  logic       res_valid;
  logic       buf_full;
  logic       out_valid;

  // Configuration writes are always taken.
  assign cfg_wr      = cfg_i.data;
  assign cfg_i.ready = 1'b1;

  pit_cfg_regs #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_i       (cfg_wr),
    .cfg_o      (cfg)
  );

  assign in_data    = in_i.data;
  assign in_i.ready = in_ready;

  pit_core #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_data_i   (in_data),
    .in_ready_o  (in_ready),
    .buf_full_i  (buf_full),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pit_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule : pwm_interval_timer

`default_nettype wire

/* rtl/core/pit_checker.sv */
// ----------------------------------------------------------------------------
// pit_checker: port-level checks for the PWM interval timer
// Watches the top-level channels and flags handshake or result slips.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_checker
  import pit_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_i,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_i
);

  // A stalled result stays on offer unchanged.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result withdrawn or changed while stalled");

  // An update always leaves the sticky flag set in the same result.
  a_event_sets_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.update_event |-> out_data_i.update_flag)
    else $error("update event reported without the update flag");

  // With nothing on offer the pipeline is empty enough to take an item.
  a_ready_when_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while no result is waiting");

  // A result can only follow an accepted item.
  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2) || $past(out_valid_i, 2)
                           || $past(in_valid_i && in_ready_i, 1))
    else $error("result offered without an accepted item");

endmodule : pit_checker

bind pwm_interval_timer pit_checker u_pit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
